// ----- rtl/dpid_pkg.sv -----
// ----------------------------------------------------------------------------
// dpid_pkg
// Shared types and constants for the dual pid controller.
// ----------------------------------------------------------------------------
package dpid_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int ERR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int CMD_W   = 16;
  localparam int LIM_W   = 23;
  localparam int ACC_W   = 24;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN_LIN  = 4'd0,
    REG_INTEG_GAIN_LIN = 4'd1,
    REG_DERIV_GAIN_LIN = 4'd2,
    REG_INTEG_LIMIT_LIN = 4'd3,
    REG_PROP_GAIN_ANG  = 4'd4,
    REG_INTEG_GAIN_ANG = 4'd5,
    REG_DERIV_GAIN_ANG = 4'd6,
    REG_INTEG_LIMIT_ANG = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] dist_error;
    logic signed [ERR_W-1:0] heading_error;
  } in_item_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] vel_cmd;
    logic signed [CMD_W-1:0] turn_cmd;
  } out_item_t;

  // gains and clamp of one channel
  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic        [LIM_W-1:0]  lim;
  } chan_cfg_t;

  // operands handed from the integrator stage to the output stage
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [ACC_W-1:0]  acc;
    logic signed [DIFF_W-1:0] diff;
  } stage_t;

endpackage

// ----- rtl/dual_pid_controller.sv -----
// ----------------------------------------------------------------------------
// dual_pid_controller
// Two pid channels (distance -> velocity, heading -> turn rate) with clamped
// integrators. Items pass the integrator stage register, then the result
// register. Throughput is one item per cycle unless out_stall holds the
// result, set by the two-stage pipe (integrator update, then gain products).
// Reset clears integrators, previous errors, gain registers and valid flags.
// ----------------------------------------------------------------------------
module dual_pid_controller #(
  parameter int FRAC_BITS = dpid_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  dpid_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dpid_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dpid_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpid_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dpid_pkg::*;

  chan_cfg_t cfg_lin;
  chan_cfg_t cfg_ang;
  stage_t    stage_lin;
  stage_t    stage_ang;
  logic      mid_valid;
  logic      adv_out;
  logic      adv_mid;
  logic      accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_lin <= '0;
      cfg_ang <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP_GAIN_LIN:   cfg_lin.kp  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN_LIN:  cfg_lin.ki  <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN_LIN:  cfg_lin.kd  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_LIMIT_LIN: cfg_lin.lim <= cfg_data[LIM_W-1:0];
        REG_PROP_GAIN_ANG:   cfg_ang.kp  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN_ANG:  cfg_ang.ki  <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN_ANG:  cfg_ang.kd  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_LIMIT_ANG: cfg_ang.lim <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe moves when the result register is empty or being taken
  assign adv_out  = !out_valid || !out_stall;
  assign adv_mid  = !mid_valid || adv_out;
  assign in_stall = !adv_mid;
  assign accept   = in_valid && adv_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_mid) begin
        mid_valid <= in_valid;
      end
      if (adv_out) begin
        out_valid <= mid_valid;
      end
    end
  end

  dpid_front u_front_lin (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .err   (in_data.dist_error),
    .lim   (cfg_lin.lim),
    .stage (stage_lin)
  );

  dpid_front u_front_ang (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .err   (in_data.heading_error),
    .lim   (cfg_ang.lim),
    .stage (stage_ang)
  );

  dpid_back #(.FRAC_BITS(FRAC_BITS)) u_back_lin (
    .clk   (clk),
    .load  (adv_out && mid_valid),
    .cfg   (cfg_lin),
    .stage (stage_lin),
    .cmd   (out_data.vel_cmd)
  );

  dpid_back #(.FRAC_BITS(FRAC_BITS)) u_back_ang (
    .clk   (clk),
    .load  (adv_out && mid_valid),
    .cfg   (cfg_ang),
    .stage (stage_ang),
    .cmd   (out_data.turn_cmd)
  );

`ifndef SYNTHESIS
  // a full pipe behind a stalled result must hold off new items
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (mid_valid && out_valid && out_stall) |-> in_stall)
    else $error("input taken while pipe is full");

  // an accepted item lands in the middle stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> mid_valid)
    else $error("accepted item lost");

  // a middle item with a free result register moves on
  a_mid_moves: assert property (@(posedge clk) disable iff (rst)
    (mid_valid && !(out_valid && out_stall)) |=> out_valid)
    else $error("middle item did not advance");

  // the distance channel's clamped integrator stays inside its limit
  a_acc_in_range: assert property (@(posedge clk) disable iff (rst)
    $past(accept) |->
      ($signed({1'b0, cfg_lin.lim}) >= stage_lin.acc &&
       -$signed({1'b0, cfg_lin.lim}) <= stage_lin.acc))
    else $error("distance integrator outside clamp");
`endif

endmodule

// ----- rtl/dpid_front.sv -----
// ----------------------------------------------------------------------------
// dpid_front
// Integrator and previous-error state of one channel, with the stage register
// that holds error, clamped integrator and error difference.
// ----------------------------------------------------------------------------
module dpid_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic signed [dpid_pkg::ERR_W-1:0]   err,
  input  logic        [dpid_pkg::LIM_W-1:0]   lim,
  output dpid_pkg::stage_t                    stage
);
  import dpid_pkg::*;

  localparam int SUM_W = ACC_W + 1;

  logic signed [ACC_W-1:0] accum;
  logic signed [ACC_W-1:0] accum_next;
  logic signed [ERR_W-1:0] last_err;
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [SUM_W-1:0] pos_lim;
  logic signed [SUM_W-1:0] neg_lim;
  logic signed [DIFF_W-1:0] diff;

  always_comb begin
    acc_sum = SUM_W'(accum) + SUM_W'(err);
    pos_lim = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
    neg_lim = -pos_lim;
    if (acc_sum > pos_lim) begin
      accum_next = ACC_W'(pos_lim);
    end else if (acc_sum < neg_lim) begin
      accum_next = ACC_W'(neg_lim);
    end else begin
      accum_next = ACC_W'(acc_sum);
    end
    diff = DIFF_W'(err) - DIFF_W'(last_err);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum    <= '0;
      last_err <= '0;
    end else if (load) begin
      accum    <= accum_next;
      last_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage.err  <= err;
      stage.acc  <= accum_next;
      stage.diff <= diff;
    end
  end

endmodule

// ----- rtl/dpid_back.sv -----
// ----------------------------------------------------------------------------
// dpid_back
// Gain products, rescale and saturation of one channel into the result
// register.
// ----------------------------------------------------------------------------
module dpid_back #(
  parameter int FRAC_BITS = dpid_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                load,
  input  dpid_pkg::chan_cfg_t                 cfg,
  input  dpid_pkg::stage_t                    stage,
  output logic signed [dpid_pkg::CMD_W-1:0]   cmd
);
  import dpid_pkg::*;

  localparam int P_W   = GAIN_W + ERR_W;
  localparam int I_W   = GAIN_W + ACC_W;
  localparam int D_W   = GAIN_W + DIFF_W;
  localparam int SUM_W = I_W + 2;

  logic signed [P_W-1:0]   p_term;
  logic signed [I_W-1:0]   i_term;
  logic signed [D_W-1:0]   d_term;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] scaled;
  logic signed [CMD_W-1:0] cmd_next;

  always_comb begin
    p_term = P_W'(cfg.kp) * P_W'(stage.err);
    i_term = I_W'(cfg.ki) * I_W'(stage.acc);
    d_term = D_W'(cfg.kd) * D_W'(stage.diff);
    sum    = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
    // arithmetic shift gives floor rounding
    scaled = sum >>> FRAC_BITS;
    if (scaled[SUM_W-1:CMD_W-1] == '0 || scaled[SUM_W-1:CMD_W-1] == '1) begin
      cmd_next = scaled[CMD_W-1:0];
    end else if (scaled[SUM_W-1]) begin
      cmd_next = {1'b1, {(CMD_W-1){1'b0}}};
    end else begin
      cmd_next = {1'b0, {(CMD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= cmd_next;
    end
  end

endmodule
